[src/cc20_pkg.sv]
// ----------------------------------------------------------------------------
// cc20_pkg
// shared types, constants and quarter-round helpers for the chacha20 block
// ----------------------------------------------------------------------------
package cc20_pkg;

	localparam int DOUBLE_ROUNDS_DEF = 10;
	localparam int WORDS             = 16;
	localparam int CHUNKS            = 8;
	localparam int CHUNK_W           = 64;
	localparam int CHUNK_IDX_W       = $clog2(CHUNKS);
	localparam int KEY_REGS          = 4;
	localparam int CFG_IDX_W         = 2;
	localparam int CFG_DATA_W        = 64;
	localparam int IN_DATA_W         = 128;

	localparam logic [CHUNK_IDX_W-1:0] LAST_CHUNK = CHUNK_IDX_W'(CHUNKS - 1);

	// rotate amounts of the quarter round, first and second half
	localparam int unsigned ROT_A0 = 16;
	localparam int unsigned ROT_B0 = 12;
	localparam int unsigned ROT_A1 = 8;
	localparam int unsigned ROT_B1 = 7;

	typedef logic [31:0] word_t;
	typedef word_t [3:0] quad_t;
	typedef word_t [WORDS-1:0] cc_state_t;
	typedef logic [CHUNKS-1:0][CHUNK_W-1:0] chunk_arr_t;
	// original words 12 to 15: counter and nonce
	typedef logic [IN_DATA_W-1:0] tail_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_WORD0 = 2'd0,
		REG_KEY_WORD1 = 2'd1,
		REG_KEY_WORD2 = 2'd2,
		REG_KEY_WORD3 = 2'd3
	} cfg_reg_e;

	// "expand 32-byte k"
	localparam quad_t SIGMA = {32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};

	function automatic word_t rotl(word_t v, int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	// one half of a quarter round: two add, xor, rotate steps
	function automatic quad_t qr_half(quad_t q, logic second);
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		int unsigned ra;
		int unsigned rb;
		a  = q[0];
		b  = q[1];
		c  = q[2];
		d  = q[3];
		ra = second ? ROT_A1 : ROT_A0;
		rb = second ? ROT_B1 : ROT_B0;
		a  = a + b;
		d  = rotl(d ^ a, ra);
		c  = c + d;
		b  = rotl(b ^ c, rb);
		return {d, c, b, a};
	endfunction

	// word index of row r in lane l, for column or diagonal rounds
	function automatic logic [3:0] qr_index(logic diag, int l, int r);
		int col;
		col = (l + (diag ? r : 0)) % 4;
		return 4'(r * 4 + col);
	endfunction

endpackage

[src/cc20_round_stage.sv]
// ----------------------------------------------------------------------------
// cc20_round_stage
// one registered half step of four parallel quarter rounds
// ----------------------------------------------------------------------------
module cc20_round_stage #(
	parameter bit DIAG   = 1'b0,
	parameter bit SECOND = 1'b0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cc20_pkg::cc_state_t  in_state,
	input  cc20_pkg::tail_t      in_tail,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cc20_pkg::cc_state_t  out_state,
	output cc20_pkg::tail_t      out_tail
);
	import cc20_pkg::*;

	logic      valid_s1;
	cc_state_t state_s1;
	tail_t     tail_s1;
	cc_state_t next_state;

	always_comb begin
		quad_t q;
		next_state = in_state;
		for (int l = 0; l < 4; l++) begin
			for (int r = 0; r < 4; r++) begin
				q[r] = in_state[qr_index(DIAG, l, r)];
			end
			q = qr_half(q, SECOND);
			for (int r = 0; r < 4; r++) begin
				next_state[qr_index(DIAG, l, r)] = q[r];
			end
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			state_s1 <= next_state;
			tail_s1  <= in_tail;
		end
	end

	assign out_valid = valid_s1;
	assign out_state = state_s1;
	assign out_tail  = tail_s1;

endmodule

[src/chacha20_keystream_block.sv]
// ----------------------------------------------------------------------------
// chacha20_keystream_block
// chacha20 block function, one keystream block per request, 8 chunks out
// ----------------------------------------------------------------------------
// usage
//  - key: four 64-bit registers written through cfg_we / cfg_index / cfg_data,
//    key bytes little-endian; write only while the block is idle
//  - slave stream: one request per 64-byte block, s_tdata carries block
//    counter, first nonce word and the 64-bit second nonce word
//  - master stream: eight 64-bit chunks per block, first keystream byte in
//    the low bits, m_tuser is the chunk index and m_tlast marks chunk seven
//  - pipeline: one entry register, four stages per double round and one
//    final add stage that also loads the chunk serialiser
//  - throughput: a request can enter every cycle while the pipeline has room;
//    sustained rate is set by the 64-bit output port, eight chunks per block
//  - reset clears all valid bits, the chunk counter and the key registers
//  - a stall on m_tready holds the current chunk; the pipeline behind it
//    fills up and s_tready drops only once every stage is occupied
// ----------------------------------------------------------------------------
module chacha20_keystream_block #(
	parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// config write port
	input  logic                                  cfg_we,
	input  cc20_pkg::cfg_reg_e                    cfg_index,
	input  logic [cc20_pkg::CFG_DATA_W-1:0]       cfg_data,
	// request stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// block_counter [31:0], nonce_lo [63:32], nonce_hi [127:64]
	input  logic [cc20_pkg::IN_DATA_W-1:0]        s_tdata,
	// keystream stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// keystream_chunk [63:0]
	output logic [cc20_pkg::CHUNK_W-1:0]          m_tdata,
	// chunk_index [2:0]
	output logic [cc20_pkg::CHUNK_IDX_W-1:0]      m_tuser,
	output logic                                  m_tlast
);
	import cc20_pkg::*;

	localparam int STAGES = 4 * DOUBLE_ROUNDS;

	// key registers
	logic [KEY_REGS-1:0][CFG_DATA_W-1:0] key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_WORD0: key_q[0] <= cfg_data;
				REG_KEY_WORD1: key_q[1] <= cfg_data;
				REG_KEY_WORD2: key_q[2] <= cfg_data;
				REG_KEY_WORD3: key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// chain of stage handshakes, entry 0 is the entry register
	logic      vld   [0:STAGES];
	logic      rdy   [0:STAGES];
	cc_state_t st    [0:STAGES];
	tail_t     tl    [0:STAGES];

	// entry register: builds the initial state
	logic      init_valid_s1;
	cc_state_t init_state_s1;
	tail_t     init_tail_s1;

	assign s_tready = !init_valid_s1 || rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			init_valid_s1 <= s_tvalid;
		end
	end

	// the user keeps the key static for requests in flight (unchecked); only the tail is carried
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			init_state_s1 <= cc_state_t'({s_tdata, key_q, SIGMA});
			init_tail_s1  <= s_tdata;
		end
	end

	assign vld[0] = init_valid_s1;
	assign st[0]  = init_state_s1;
	assign tl[0]  = init_tail_s1;

	// per double round: column first half, column second half, diagonal halves
	for (genvar k = 0; k < STAGES; k++) begin : g_round
		cc20_round_stage #(
			.DIAG   (((k / 2) % 2) == 1),
			.SECOND ((k % 2) == 1)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[k]),
			.in_ready  (rdy[k]),
			.in_state  (st[k]),
			.in_tail   (tl[k]),
			.out_valid (vld[k+1]),
			.out_ready (rdy[k+1]),
			.out_state (st[k+1]),
			.out_tail  (tl[k+1])
		);
	end

	// final feed-forward add and chunk serialiser
	logic                   ser_valid_q;
	logic [CHUNK_IDX_W-1:0] chunk_idx_q;
	chunk_arr_t             blk_q;
	cc_state_t              orig_state;
	cc_state_t              sum_state;
	logic                   chunk_done;

	always_comb begin
		orig_state = cc_state_t'({tl[STAGES], key_q, SIGMA});
		for (int i = 0; i < WORDS; i++) begin
			sum_state[i] = st[STAGES][i] + orig_state[i];
		end
	end

	assign chunk_done     = m_tvalid && m_tready;
	assign rdy[STAGES]    = !ser_valid_q || (chunk_done && chunk_idx_q == LAST_CHUNK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_valid_q <= 1'b0;
			chunk_idx_q <= '0;
		end else if (rdy[STAGES]) begin
			ser_valid_q <= vld[STAGES];
			chunk_idx_q <= '0;
		end else if (chunk_done) begin
			chunk_idx_q <= chunk_idx_q + CHUNK_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[STAGES] && vld[STAGES]) begin
			blk_q <= chunk_arr_t'(sum_state);
		end
	end

	assign m_tvalid = ser_valid_q;
	assign m_tdata  = blk_q[chunk_idx_q];
	assign m_tuser  = chunk_idx_q;
	assign m_tlast  = (chunk_idx_q == LAST_CHUNK);

	// a block never leaves the serialiser before its last chunk is taken
	a_block_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("serialiser dropped a block before its last chunk");

	// chunks of a block come out in order
	a_chunk_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tuser == $past(m_tuser) + CHUNK_IDX_W'(1))
		else $error("chunk index did not advance by one");

	// a new block that starts from an idle output begins at chunk zero
	a_block_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> m_tuser == '0)
		else $error("block started at a nonzero chunk index");

	// back-pressure only reaches the input once the entry register and the serialiser are both occupied
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> init_valid_s1 && ser_valid_q)
		else $error("request refused while pipeline had room");

	// when the last chunk goes with nothing behind it, the output drains
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast && !vld[STAGES] |=> !m_tvalid)
		else $error("output valid without a block behind it");

endmodule

[tb/tb_chacha20_keystream_block.sv]
// ----------------------------------------------------------------------------
// tb_chacha20_keystream_block
// self-checking bench for the chacha20 keystream block: a behavioural
// block-function model predicts the eight 64-bit chunks of every accepted
// request, and a scoreboard checks them in order against the master stream
// while, outside the steady stretch, both stream sides idle at random
// ----------------------------------------------------------------------------
module tb_chacha20_keystream_block;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROUNDS              = 10;
	// one entry register, four stages per double round, one final add stage
	localparam int FIRST_CHUNK_LATENCY = 4 * ROUNDS + 2;
	localparam int CYCLE_LIMIT         = 400000;
	localparam int IDLE_PCT            = 18;
	localparam int CHUNKS_PER_BLOCK    = 8;
	localparam int MAX_REPORTS         = 10;

	// "expand 32-byte k", word 0 in the low bits
	localparam logic [127:0] EXPAND_32_BYTE_K =
		{32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};

	typedef logic [31:0] lane_t;
	typedef lane_t [15:0] block_words_t;

	typedef struct packed {
		logic [cc20_pkg::CHUNK_W-1:0]     chunk;
		logic [cc20_pkg::CHUNK_IDX_W-1:0] index;
		logic                             last;
	} keystream_chunk_t;

	// ---------------------------------------------------------------- dut i/o
	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                cfg_we    = 1'b0;
	cc20_pkg::cfg_reg_e                  cfg_index = cc20_pkg::REG_KEY_WORD0;
	logic [cc20_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;
	logic                                s_tvalid  = 1'b0;
	logic                                s_tready;
	// block_counter [31:0], nonce_lo [63:32], nonce_hi [127:64]
	logic [cc20_pkg::IN_DATA_W-1:0]      s_tdata   = '0;
	logic                                m_tvalid;
	logic                                m_tready  = 1'b0;
	// keystream_chunk [63:0]
	logic [cc20_pkg::CHUNK_W-1:0]        m_tdata;
	// chunk_index [2:0]
	logic [cc20_pkg::CHUNK_IDX_W-1:0]    m_tuser;
	logic                                m_tlast;

	// ------------------------------------------------------ bench-side state
	// copy of the key registers as the block should hold them
	logic [63:0]          key_shadow [4] = '{default: '0};
	// chunks still owed by the block, oldest first
	keystream_chunk_t     keystream_q [$];
	// random idling on both stream sides; cleared for the steady stretch
	bit                   gaps_on      = 1'b1;
	int unsigned          cycle_count  = 0;
	int unsigned          mismatches   = 0;
	// running counter and nonce, so most random requests step like a consumer
	lane_t                run_counter  = '0;
	lane_t                run_nonce_lo = '0;
	logic [63:0]          run_nonce_hi = '0;

	chacha20_keystream_block #(
		.DOUBLE_ROUNDS(ROUNDS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	// run limit, far above the slowest legal run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------- predictor
	function automatic lane_t rotl32(lane_t v, int unsigned n);
		logic [63:0] twice;
		twice = {v, v} << n;
		return twice[63:32];
	endfunction

	function automatic block_words_t quarter_round(block_words_t w, int a, int b, int c, int d);
		w[a] = w[a] + w[b];  w[d] = rotl32(w[d] ^ w[a], 16);
		w[c] = w[c] + w[d];  w[b] = rotl32(w[b] ^ w[c], 12);
		w[a] = w[a] + w[b];  w[d] = rotl32(w[d] ^ w[a], 8);
		w[c] = w[c] + w[d];  w[b] = rotl32(w[b] ^ w[c], 7);
		return w;
	endfunction

	// works out the 64 keystream bytes of one request and queues its chunks
	function automatic void predict_keystream(lane_t counter, lane_t nonce_lo,
		logic [63:0] nonce_hi);
		block_words_t     init_w;
		block_words_t     mix_w;
		keystream_chunk_t item;
		int               i;
		for (i = 0; i < 4; i++) begin
			init_w[i]         = EXPAND_32_BYTE_K[32*i +: 32];
			init_w[4 + 2 * i] = key_shadow[i][31:0];
			init_w[5 + 2 * i] = key_shadow[i][63:32];
		end
		init_w[12] = counter;
		init_w[13] = nonce_lo;
		init_w[14] = nonce_hi[31:0];
		init_w[15] = nonce_hi[63:32];
		mix_w = init_w;
		for (i = 0; i < ROUNDS; i++) begin
			// columns
			mix_w = quarter_round(mix_w, 0, 4, 8, 12);
			mix_w = quarter_round(mix_w, 1, 5, 9, 13);
			mix_w = quarter_round(mix_w, 2, 6, 10, 14);
			mix_w = quarter_round(mix_w, 3, 7, 11, 15);
			// diagonals
			mix_w = quarter_round(mix_w, 0, 5, 10, 15);
			mix_w = quarter_round(mix_w, 1, 6, 11, 12);
			mix_w = quarter_round(mix_w, 2, 7, 8, 13);
			mix_w = quarter_round(mix_w, 3, 4, 9, 14);
		end
		for (i = 0; i < 16; i++)
			mix_w[i] = mix_w[i] + init_w[i];
		for (i = 0; i < CHUNKS_PER_BLOCK; i++) begin
			item.chunk = {mix_w[2 * i + 1], mix_w[2 * i]};
			item.index = cc20_pkg::CHUNK_IDX_W'(i);
			item.last  = (i == CHUNKS_PER_BLOCK - 1);
			keystream_q = {keystream_q, item};
		end
	endfunction

	// ------------------------------------------------------------ scoreboard
	function automatic void log_keystream_error(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] keystream error: %s", $realtime, msg);
	endfunction

	// sink side: random back-pressure on the chunk stream
	always @(posedge clk)
		m_tready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);

	// every chunk taken is held against the oldest one still owed
	always @(posedge clk) begin
		keystream_chunk_t want;
		if (m_tvalid && m_tready) begin
			if (keystream_q.size() == 0) begin
				log_keystream_error($sformatf("chunk with none owed: data %h index %0d last %0b",
					m_tdata, m_tuser, m_tlast));
			end else begin
				want = keystream_q.pop_front();
				if (m_tdata !== want.chunk || m_tuser !== want.index || m_tlast !== want.last)
					log_keystream_error($sformatf(
						"expected data %h index %0d last %0b, got data %h index %0d last %0b",
						want.chunk, want.index, want.last, m_tdata, m_tuser, m_tlast));
			end
		end
	end

	// -------------------------------------------------------- stimulus tasks
	function automatic lane_t pick_word();
		case ($urandom_range(15))
			0:       return '0;
			1:       return '1;
			default: return $urandom();
		endcase
	endfunction

	// one request; tvalid stays high after acceptance so the next request
	// can follow on the very next edge
	task automatic send_request(lane_t counter, lane_t nonce_lo, logic [63:0] nonce_hi);
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {nonce_hi, nonce_lo, counter};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_keystream(counter, nonce_lo, nonce_hi);
	endtask

	// sender stops and waits until every owed chunk has been taken
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (keystream_q.size() != 0)
			@(posedge clk);
	endtask

	// leaves cfg_we high; the caller lowers it after its last write
	task automatic write_key_reg(cc20_pkg::cfg_reg_e which, logic [63:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		@(posedge clk);
		key_shadow[which] = value;
	endtask

	task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
		logic [63:0] k3);
		write_key_reg(cc20_pkg::REG_KEY_WORD0, k0);
		write_key_reg(cc20_pkg::REG_KEY_WORD1, k1);
		write_key_reg(cc20_pkg::REG_KEY_WORD2, k2);
		write_key_reg(cc20_pkg::REG_KEY_WORD3, k3);
		cfg_we <= 1'b0;
	endtask

	// mostly counter steps within one nonce, as a consumer walks a message,
	// sometimes a fresh counter and nonce
	task automatic send_random_requests(int count);
		int n;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(99) < 40) begin
				run_counter  = pick_word();
				run_nonce_lo = pick_word();
				run_nonce_hi = {pick_word(), pick_word()};
			end else begin
				run_counter = run_counter + 1;
			end
			send_request(run_counter, run_nonce_lo, run_nonce_hi);
		end
	endtask

	// ------------------------------------------------------------ test tasks
	// key never written: registers must read as zero
	task automatic test_key_after_reset();
		send_request('0, '0, '0);
		send_request('1, '1, '1);
	endtask

	// known block from the standard: key bytes 00..1f, counter 1
	task automatic test_standard_block();
		wait_drained();
		load_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
			64'h1716151413121110, 64'h1f1e1d1c1b1a1918);
		send_request(32'h00000001, 32'h09000000, 64'h00000000_4a000000);
	endtask

	// all-ones key, field extremes and alternating bit patterns,
	// counter at its maximum used as given
	task automatic test_field_extremes();
		wait_drained();
		load_key('1, '1, '1, '1);
		send_request('0, '0, '0);
		send_request('1, '1, '1);
		send_request('1, '0, '0);
		send_request(32'haaaaaaaa, 32'h55555555, 64'haaaaaaaa_aaaaaaaa);
		send_request(32'h55555555, 32'haaaaaaaa, 64'h55555555_55555555);
		send_request(32'h80000000, 32'h00000001, 64'h80000000_00000001);
		send_request(32'h00000001, 32'h80000000, 64'h00000001_80000000);
	endtask

	// one register at a time: the other three must keep their values
	task automatic test_single_key_writes();
		wait_drained();
		load_key('0, '0, '0, '0);
		write_key_reg(cc20_pkg::REG_KEY_WORD2, {$urandom(), $urandom()});
		cfg_we <= 1'b0;
		send_request(32'h00000007, pick_word(), {pick_word(), pick_word()});
		wait_drained();
		write_key_reg(cc20_pkg::REG_KEY_WORD0, {$urandom(), $urandom()});
		cfg_we <= 1'b0;
		send_request(32'h00000008, pick_word(), {pick_word(), pick_word()});
		wait_drained();
		write_key_reg(cc20_pkg::REG_KEY_WORD3, 64'hffffffff_00000000);
		write_key_reg(cc20_pkg::REG_KEY_WORD1, 64'h00000000_ffffffff);
		cfg_we <= 1'b0;
		send_request(pick_word(), pick_word(), {pick_word(), pick_word()});
	endtask

	// no idling either side: requests enter back to back and chunks leave without gaps
	task automatic test_steady_stream();
		wait_drained();
		load_key({$urandom(), $urandom()}, {$urandom(), $urandom()},
			{$urandom(), $urandom()}, {$urandom(), $urandom()});
		gaps_on = 1'b0;
		send_random_requests(40);
		gaps_on = 1'b1;
	endtask

	// random traffic over three keys, drained before each key load and once within the first key's phase
	task automatic test_random_traffic();
		wait_drained();
		load_key({$urandom(), $urandom()}, {$urandom(), $urandom()},
			{$urandom(), $urandom()}, {$urandom(), $urandom()});
		send_random_requests(40);
		// sender holds off until the block has emptied, then carries on
		wait_drained();
		send_random_requests(40);

		wait_drained();
		load_key(64'haaaaaaaa_55555555, 64'h55555555_aaaaaaaa,
			64'hffffffff_ffffffff, 64'h00000000_00000000);
		send_random_requests(60);

		wait_drained();
		load_key({pick_word(), pick_word()}, {pick_word(), pick_word()},
			{pick_word(), pick_word()}, {pick_word(), pick_word()});
		send_random_requests(80);
	endtask

	// ------------------------------------------------------------- main flow
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_key_after_reset();
		test_standard_block();
		test_field_extremes();
		test_single_key_writes();
		test_steady_stream();
		test_random_traffic();

		// all owed chunks in, then a wait for strays
		wait_drained();
		repeat (FIRST_CHUNK_LATENCY + CHUNKS_PER_BLOCK) @(posedge clk);

		if (mismatches == 0 && keystream_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
